FILE: sv/rfop_pkg.sv
package rfop_pkg;

  localparam logic [2:0] REQ_PUSH     = 3'd0;
  localparam logic [2:0] REQ_POP      = 3'd1;
  localparam logic [2:0] REQ_PEEK     = 3'd2;
  localparam logic [2:0] REQ_PEEK_AT  = 3'd3;
  localparam logic [2:0] REQ_CLEAR    = 3'd4;
  localparam logic [2:0] REQ_CLR_DROP = 3'd5;

  localparam logic [31:0] DROP_MAX = 32'hFFFF_FFFF;
  localparam int          CAP_RESET = 64;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
  } ctrl_cmd_t;

endpackage

FILE: sv/rfop_ctrl.sv
module rfop_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output rfop_pkg::ctrl_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: state_next = ST_RESP;
      ST_RESP: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy     = (state != ST_IDLE);
  assign done     = (state == ST_RESP);
  assign cmd.load = (state == ST_IDLE) && start;
  assign cmd.exec = (state == ST_EXEC);
  assign cmd.resp = (state == ST_RESP);

endmodule

FILE: sv/rfop_dp.sv
module rfop_dp #(
  parameter int MAX_DEPTH = 64,
  parameter int ELEM_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  rfop_pkg::ctrl_cmd_t cmd,
  input  logic                cfg_write,
  input  logic [6:0]          cfg_data,
  input  logic [2:0]          req_type,
  input  logic [31:0]         push_data,
  input  logic                overwrite_when_full,
  input  logic [5:0]          peek_index,
  output logic                ok,
  output logic [31:0]         read_data,
  output logic [6:0]          fill_count,
  output logic                is_full,
  output logic                is_empty,
  output logic [31:0]         drop_total
);

  localparam int PW   = $clog2(MAX_DEPTH);
  localparam int CNTW = $clog2(MAX_DEPTH + 1);
  localparam int AW   = ((CNTW > 6) ? CNTW : 6) + 1;
  localparam int RST_CAP = (MAX_DEPTH < rfop_pkg::CAP_RESET) ? MAX_DEPTH
                                                             : rfop_pkg::CAP_RESET;

  logic [ELEM_BITS-1:0] mem [MAX_DEPTH];

  logic [2:0]           req;
  logic [ELEM_BITS-1:0] data;
  logic                 ow;
  logic [5:0]           idx;
  logic [CNTW-1:0]      cap;
  logic [PW-1:0]        wp;
  logic [CNTW-1:0]      cnt;
  logic [31:0]          drops;
  logic                 rd_sel;
  logic [ELEM_BITS-1:0] rdq;

  logic [ELEM_BITS+31:0] push_wide;
  logic [ELEM_BITS+31:0] rd_wide;
  logic [CNTW+6:0]       cfg_ext;
  logic [CNTW-1:0]       cap_next;
  logic [CNTW+7:0]       cnt_ext;

  logic [AW-1:0] cap_a;
  logic [AW-1:0] cnt_a;
  logic [AW-1:0] wp_a;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] old_sum;
  logic [AW-1:0] oldest;
  logic [AW-1:0] pos_sum;
  logic [AW-1:0] pos;
  logic [AW-1:0] wp_sum;
  logic [AW-1:0] wp_inc;
  logic          full;
  logic          push_take;

  assign push_wide = {{32{1'b0}}, push_data};
  assign cfg_ext   = {{CNTW{1'b0}}, cfg_data};

  always_comb begin
    if (cfg_ext == '0) begin
      cap_next = CNTW'(1);
    end else if (cfg_ext > (CNTW+7)'(MAX_DEPTH)) begin
      cap_next = CNTW'(MAX_DEPTH);
    end else begin
      cap_next = cfg_ext[CNTW-1:0];
    end
  end

  assign cap_a = {{(AW-CNTW){1'b0}}, cap};
  assign cnt_a = {{(AW-CNTW){1'b0}}, cnt};
  assign wp_a  = {{(AW-PW){1'b0}}, wp};
  assign idx_a = (req == rfop_pkg::REQ_PEEK_AT) ? {{(AW-6){1'b0}}, idx} : '0;

  always_comb begin
    old_sum = wp_a + (cap_a - cnt_a);
    oldest  = (old_sum >= cap_a) ? old_sum - cap_a : old_sum;
    pos_sum = oldest + idx_a;
    pos     = (pos_sum >= cap_a) ? pos_sum - cap_a : pos_sum;
    wp_sum  = wp_a + AW'(1);
    wp_inc  = (wp_sum >= cap_a) ? wp_sum - cap_a : wp_sum;
  end

  assign full      = (cnt == cap);
  assign push_take = !full || ow;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req  <= req_type;
      data <= push_wide[ELEM_BITS-1:0];
      ow   <= overwrite_when_full;
      idx  <= peek_index;
    end
    if (cmd.exec) begin
      rdq <= mem[pos[PW-1:0]];
      if (req == rfop_pkg::REQ_PUSH && push_take) begin
        mem[wp] <= data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap    <= CNTW'(RST_CAP);
      wp     <= '0;
      cnt    <= '0;
      drops  <= '0;
      ok     <= 1'b0;
      rd_sel <= 1'b0;
    end else if (cfg_write) begin
      cap   <= cap_next;
      wp    <= '0;
      cnt   <= '0;
      drops <= '0;
    end else if (cmd.exec) begin
      ok     <= 1'b0;
      rd_sel <= 1'b0;
      case (req)
        rfop_pkg::REQ_PUSH: begin
          if (push_take) begin
            wp <= wp_inc[PW-1:0];
            if (!full) cnt <= cnt + CNTW'(1);
            ok <= 1'b1;
          end else if (drops != rfop_pkg::DROP_MAX) begin
            drops <= drops + 32'd1;
          end
        end
        rfop_pkg::REQ_POP, rfop_pkg::REQ_PEEK: begin
          if (cnt != '0) begin
            if (req == rfop_pkg::REQ_POP) cnt <= cnt - CNTW'(1);
            ok     <= 1'b1;
            rd_sel <= 1'b1;
          end
        end
        rfop_pkg::REQ_PEEK_AT: begin
          if ({{(AW-6){1'b0}}, idx} < cnt_a) begin
            ok     <= 1'b1;
            rd_sel <= 1'b1;
          end
        end
        rfop_pkg::REQ_CLEAR: begin
          wp <= '0;
          cnt <= '0;
          ok <= 1'b1;
        end
        rfop_pkg::REQ_CLR_DROP: begin
          drops <= '0;
          ok <= 1'b1;
        end
        default: begin
          ok <= 1'b0;
        end
      endcase
    end
  end

  assign rd_wide    = {{32{1'b0}}, rdq};
  assign read_data  = rd_sel ? rd_wide[31:0] : 32'd0;
  assign cnt_ext    = {{8{1'b0}}, cnt};
  assign fill_count = cnt_ext[6:0];
  assign is_full    = full;
  assign is_empty   = (cnt == '0);
  assign drop_total = drops;

endmodule

FILE: sv/ring_fifo_overwrite_peek_top.sv
// Sequence: a request accepted in the idle state goes through the execute state and gives
// its result, with done high, in the respond state. A new request is taken only once the
// block is back in the idle state. Reset: synchronous; clears pointers, fill count, drop
// counter and sets capacity to min(MAX_DEPTH, 64). The element store is not cleared; the
// receiver cannot stall a result beat.
module ring_fifo_overwrite_peek_top #(
  parameter int MAX_DEPTH = 64,
  parameter int ELEM_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  req_type,
  input  logic [31:0] push_data,
  input  logic        overwrite_when_full,
  input  logic [5:0]  peek_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data,
  output logic        done,
  output logic        ok,
  output logic [31:0] read_data,
  output logic [6:0]  fill_count,
  output logic        is_full,
  output logic        is_empty,
  output logic [31:0] drop_total
);

  rfop_pkg::ctrl_cmd_t cmd;

  assign cfg_ready = !busy && !start;

  rfop_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  rfop_dp #(
    .MAX_DEPTH (MAX_DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .cfg_write           (cfg_valid && cfg_ready),
    .cfg_data            (cfg_data),
    .req_type            (req_type),
    .push_data           (push_data),
    .overwrite_when_full (overwrite_when_full),
    .peek_index          (peek_index),
    .ok                  (ok),
    .read_data           (read_data),
    .fill_count          (fill_count),
    .is_full             (is_full),
    .is_empty            (is_empty),
    .drop_total          (drop_total)
  );

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##2 done)
    else $error("result beat missing");

  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  a_full_not_empty: assert property (@(posedge clk) disable iff (rst)
    done |-> !(is_full && is_empty))
    else $error("full and empty together");

  a_cfg_reinit: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |=> (fill_count == 7'd0 && drop_total == 32'd0))
    else $error("capacity write did not reinitialize");

endmodule

FILE: tb/ring_fifo_overwrite_peek_top_tb.sv
`timescale 1ns / 1ps

module ring_fifo_overwrite_peek_top_tb;

  localparam logic [2:0] REQ_BAD_LO = 3'd6;
  localparam logic [2:0] REQ_BAD_HI = 3'd7;
  localparam int RING_SLOTS = 64;
  localparam int CFG_SETTLE = 4;
  localparam int END_SETTLE = 8;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASE_ITEMS = 135;

  typedef enum logic [1:0] {STEP_REQ, STEP_CFG, STEP_DRAIN, STEP_IDLE} step_kind_t;

  typedef struct {
    step_kind_t  kind;
    logic [2:0]  req;
    logic [31:0] data;
    logic        ow;
    logic [5:0]  idx;
    logic [6:0]  cap;
    int          cycles;
  } plan_step_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] data;
    logic [6:0]  count;
    logic        full;
    logic        empty;
    logic [31:0] drops;
  } fifo_status_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [2:0]  req_type = rfop_pkg::REQ_PUSH;
  logic [31:0] push_data = '0;
  logic        overwrite_when_full = 1'b0;
  logic [5:0]  peek_index = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [6:0]  cfg_data = '0;
  logic        done;
  logic        ok;
  logic [31:0] read_data;
  logic [6:0]  fill_count;
  logic        is_full;
  logic        is_empty;
  logic [31:0] drop_total;

  ring_fifo_overwrite_peek_top dut (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .req_type            (req_type),
    .push_data           (push_data),
    .overwrite_when_full (overwrite_when_full),
    .peek_index          (peek_index),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_data            (cfg_data),
    .done                (done),
    .ok                  (ok),
    .read_data           (read_data),
    .fill_count          (fill_count),
    .is_full             (is_full),
    .is_empty            (is_empty),
    .drop_total          (drop_total)
  );

  plan_step_t   request_plan[$];
  fifo_status_t pending_status[$];

  logic [31:0] ring_store [RING_SLOTS];
  int          ring_wpos;
  int          ring_count;
  logic [31:0] ring_drops;
  logic [6:0]  ring_cap_reg;

  int sent_count = 0;
  int seen_count = 0;
  int quiet = 0;
  int gap_left = 0;
  int errors = 0;
  int stall_cycles = 0;
  logic all_issued = 1'b0;
  logic calm = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int ring_cap();
    if (ring_cap_reg == 0) return 1;
    if (ring_cap_reg > RING_SLOTS) return RING_SLOTS;
    return ring_cap_reg;
  endfunction

  function automatic void apply_request(logic [2:0] rq, logic [31:0] d, logic ow,
                                        logic [5:0] ix);
    int cap;
    int pos;
    fifo_status_t st;
    cap = ring_cap();
    st = '0;
    if (ring_wpos >= cap) ring_wpos = 0;
    if (ring_count > cap) ring_count = cap;
    case (rq)
      rfop_pkg::REQ_PUSH: begin
        if (ring_count >= cap && !ow) begin
          if (ring_drops != rfop_pkg::DROP_MAX) ring_drops = ring_drops + 1;
        end else begin
          if (ring_count < cap) ring_count++;
          ring_store[ring_wpos] = d;
          ring_wpos = (ring_wpos + 1) % cap;
          st.ok = 1'b1;
        end
      end
      rfop_pkg::REQ_POP, rfop_pkg::REQ_PEEK: begin
        if (ring_count != 0) begin
          pos = (ring_wpos + cap - ring_count) % cap;
          st.data = ring_store[pos];
          if (rq == rfop_pkg::REQ_POP) ring_count--;
          st.ok = 1'b1;
        end
      end
      rfop_pkg::REQ_PEEK_AT: begin
        if (ix < ring_count) begin
          pos = (ring_wpos + cap - ring_count + ix) % cap;
          st.data = ring_store[pos];
          st.ok = 1'b1;
        end
      end
      rfop_pkg::REQ_CLEAR: begin
        ring_wpos = 0;
        ring_count = 0;
        st.ok = 1'b1;
      end
      rfop_pkg::REQ_CLR_DROP: begin
        ring_drops = '0;
        st.ok = 1'b1;
      end
      default: ;
    endcase
    st.count = ring_count[6:0];
    st.full = (ring_count == cap);
    st.empty = (ring_count == 0);
    st.drops = ring_drops;
    pending_status.push_back(st);
  endfunction

  function automatic void write_capacity(logic [6:0] value);
    ring_cap_reg = value;
    ring_wpos = 0;
    ring_count = 0;
    ring_drops = '0;
  endfunction

  function automatic void add_req(logic [2:0] rq, logic [31:0] d, logic ow, logic [5:0] ix);
    plan_step_t s;
    if (!calm && $urandom_range(0, 99) < 29) begin
      s = '{STEP_IDLE, rfop_pkg::REQ_PUSH, '0, 1'b0, '0, '0, $urandom_range(1, 5)};
      request_plan.push_back(s);
    end
    s = '{STEP_REQ, rq, d, ow, ix, '0, 0};
    request_plan.push_back(s);
  endfunction

  function automatic void add_step(step_kind_t kind, logic [6:0] cap);
    plan_step_t s;
    s = '{kind, rfop_pkg::REQ_PUSH, '0, 1'b0, '0, cap, 0};
    request_plan.push_back(s);
  endfunction

  function automatic logic [31:0] pick_data();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_phase(logic [6:0] cap, int n, int push_pct, logic no_idle);
    int span;
    int r;
    logic [2:0] rq;
    logic [5:0] ix;
    span = (cap == 0) ? 1 : (cap > 63 ? 63 : cap);
    calm = no_idle;
    add_step(STEP_CFG, cap);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) add_step(STEP_DRAIN, '0);
      r = $urandom_range(0, 99);
      if (r < push_pct) begin
        rq = rfop_pkg::REQ_PUSH;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 38) rq = rfop_pkg::REQ_POP;
        else if (r < 60) rq = rfop_pkg::REQ_PEEK;
        else if (r < 90) rq = rfop_pkg::REQ_PEEK_AT;
        else if (r < 94) rq = rfop_pkg::REQ_CLEAR;
        else if (r < 97) rq = rfop_pkg::REQ_CLR_DROP;
        else rq = $urandom_range(0, 1) ? REQ_BAD_HI : REQ_BAD_LO;
      end
      ix = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, span)) : 6'($urandom);
      add_req(rq, pick_data(), 1'($urandom), ix);
    end
    calm = 1'b0;
  endfunction

  always @(posedge clk) begin : drive
    logic next_start;
    logic next_cfg;
    logic idle_now;
    plan_step_t head;
    idle_now = (sent_count == seen_count) && !start && !cfg_valid;
    if (rst) begin
      start <= 1'b0;
      cfg_valid <= 1'b0;
      quiet <= 0;
      all_issued <= 1'b0;
      ring_wpos = 0;
      ring_count = 0;
      ring_drops = '0;
      ring_cap_reg = 7'(rfop_pkg::CAP_RESET);
      gap_left = 0;
    end else begin
      next_start = start;
      next_cfg = cfg_valid;
      if (start && !busy) begin
        apply_request(req_type, push_data, overwrite_when_full, peek_index);
        sent_count <= sent_count + 1;
        next_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        write_capacity(cfg_data);
        next_cfg = 1'b0;
      end
      if (!next_start && !next_cfg && request_plan.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          head = request_plan[0];
          case (head.kind)
            STEP_IDLE: begin
              void'(request_plan.pop_front());
              gap_left = head.cycles;
            end
            STEP_REQ: begin
              void'(request_plan.pop_front());
              req_type <= head.req;
              push_data <= head.data;
              overwrite_when_full <= head.ow;
              peek_index <= head.idx;
              next_start = 1'b1;
            end
            STEP_CFG: begin
              if (idle_now && quiet >= CFG_SETTLE) begin
                void'(request_plan.pop_front());
                cfg_data <= head.cap;
                next_cfg = 1'b1;
              end
            end
            default: begin
              if (idle_now) void'(request_plan.pop_front());
            end
          endcase
        end
      end
      start <= next_start;
      cfg_valid <= next_cfg;
      quiet <= idle_now ? quiet + 1 : 0;
      all_issued <= (request_plan.size() == 0);
    end
  end

  always @(posedge clk) begin : check
    fifo_status_t want;
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, ok=%0b data=%h count=%0d",
                 $time, ok, read_data, fill_count);
      end else begin
        want = pending_status.pop_front();
        seen_count <= seen_count + 1;
        if (ok !== want.ok) begin
          errors++;
          $display("%0t: ok expected %0b actual %0b", $time, want.ok, ok);
        end
        if (read_data !== want.data) begin
          errors++;
          $display("%0t: read_data expected %h actual %h", $time, want.data, read_data);
        end
        if (fill_count !== want.count) begin
          errors++;
          $display("%0t: fill_count expected %0d actual %0d", $time, want.count, fill_count);
        end
        if (is_full !== want.full) begin
          errors++;
          $display("%0t: is_full expected %0b actual %0b", $time, want.full, is_full);
        end
        if (is_empty !== want.empty) begin
          errors++;
          $display("%0t: is_empty expected %0b actual %0b", $time, want.empty, is_empty);
        end
        if (drop_total !== want.drops) begin
          errors++;
          $display("%0t: drop_total expected %0d actual %0d", $time, want.drops, drop_total);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [6:0] caps [10];
    caps = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd65, 7'd17, 7'd33, 7'd2, 7'd64};

    // empty ring at reset capacity
    add_req(rfop_pkg::REQ_POP, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PEEK, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PEEK_AT, 32'h0, 1'b0, 6'd0);
    add_step(STEP_CFG, 7'd2);
    add_req(rfop_pkg::REQ_PUSH, 32'h0000_0000, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PUSH, 32'hFFFF_FFFF, 1'b1, 6'd63);
    add_req(rfop_pkg::REQ_PUSH, 32'h1234_5678, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PUSH, 32'hA5A5_A5A5, 1'b1, 6'd0);
    add_req(rfop_pkg::REQ_PEEK, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PEEK_AT, 32'h0, 1'b0, 6'd1);
    add_req(rfop_pkg::REQ_PEEK_AT, 32'h0, 1'b0, 6'd2);
    add_req(rfop_pkg::REQ_PEEK_AT, 32'h0, 1'b0, 6'd63);
    add_req(REQ_BAD_LO, 32'hFFFF_FFFF, 1'b1, 6'd63);
    add_req(REQ_BAD_HI, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_POP, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_POP, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_POP, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_CLR_DROP, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PUSH, 32'h5A5A_5A5A, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_CLEAR, 32'h0, 1'b0, 6'd0);
    add_req(rfop_pkg::REQ_PEEK, 32'h0, 1'b0, 6'd0);

    for (int p = 0; p < 10; p++) begin
      add_phase(caps[p], PHASE_ITEMS, (p % 2 == 1) ? 75 : 55, p == 3);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    forever begin
      @(posedge clk);
      if (all_issued && quiet >= END_SETTLE) break;
    end
    if (pending_status.size() != 0) begin
      errors++;
      $display("%0t: %0d results never arrived", $time, pending_status.size());
    end
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
